>>> rtl/s98_command_stream_parser_macros.svh
// Assertion helpers shared by the parser RTL.
`ifndef S98_COMMAND_STREAM_PARSER_MACROS_SVH
`define S98_COMMAND_STREAM_PARSER_MACROS_SVH

// Checks a property on every rising edge outside of reset.
`define S98CSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define S98CSP_ASSERT_NEXT(lbl, pre, post, msg) \
  `S98CSP_ASSERT(lbl, (pre) |=> (post), msg)

`endif

>>> rtl/s98csp_pkg.sv
package s98csp_pkg;

  typedef enum logic [1:0] {
    KIND_WRITE   = 2'd0,
    KIND_WAIT    = 2'd1,
    KIND_END     = 2'd2,
    KIND_UNKNOWN = 2'd3
  } kind_e;

  typedef enum logic [6:0] {
    PH_OPCODE = 7'b0000001,
    PH_ADDR   = 7'b0000010,
    PH_DATA   = 7'b0000100,
    PH_VARINT = 7'b0001000,
    PH_SKIP1  = 7'b0010000,
    PH_SKIP2  = 7'b0100000,
    PH_ENDED  = 7'b1000000
  } phase_e;

  localparam logic [7:0] OP_WRITE  = 8'h00;
  localparam logic [7:0] OP_WAIT1  = 8'hff;
  localparam logic [7:0] OP_WAITN  = 8'hfe;
  localparam logic [7:0] OP_END    = 8'hfd;

  localparam int unsigned AccW   = 28;
  localparam int unsigned TicksW = 29;

  localparam logic [AccW-1:0]   AccMax       = {AccW{1'b1}};
  localparam logic [TicksW-1:0] TicksOne     = TicksW'(1);
  localparam logic [TicksW-1:0] TicksSat     = {1'b0, AccMax} + TicksW'(2);

endpackage

>>> rtl/s98_command_stream_parser.sv
// Decodes the command section of a sound-chip register dump, one byte per
// word on the cmd channel, into register-write, wait, end and unknown-opcode
// results on the res channel. The parser accepts a new byte each cycle while
// the result register is empty or being drained; a result is registered and
// presented in the cycle after the byte that completes it. Address, skipped
// and non-final varint bytes give no result. After the end opcode all bytes
// are taken and dropped until reset. Varint waits saturate at 2^28 + 1
// ticks; VARINT_MAX_BYTES sets how many varint bytes are added into the
// count.
`include "s98_command_stream_parser_macros.svh"

module s98_command_stream_parser #(
  parameter int unsigned VARINT_MAX_BYTES = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  output logic                  cmd_ready_o,
  input  logic [7:0]            cmd_byte_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output s98csp_pkg::kind_e     kind_o,
  output logic [7:0]            reg_address_o,
  output logic [7:0]            reg_data_o,
  output logic [28:0]           wait_ticks_o
);
  import s98csp_pkg::*;

  localparam int unsigned IdxW = $clog2(VARINT_MAX_BYTES + 1);
  localparam int unsigned SumW = (7 * VARINT_MAX_BYTES > AccW) ? 7 * VARINT_MAX_BYTES : AccW;
  localparam logic [IdxW-1:0] IdxMax = IdxW'(VARINT_MAX_BYTES);

  phase_e             phase_q, phase_d;
  logic [7:0]         held_addr_q, held_addr_d;
  logic [AccW-1:0]    accum_q, accum_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic               sat_q, sat_d;

  logic               res_valid_q, res_valid_d;
  kind_e              kind_q, kind_d;
  logic [7:0]         addr_q, addr_d;
  logic [7:0]         data_q, data_d;
  logic [TicksW-1:0]  ticks_q, ticks_d;

  logic               cmd_fire;
  logic               emit;
  logic [6:0]         payload;
  logic [SumW-1:0]    sum;
  logic               sum_over;

  assign cmd_ready_o = !res_valid_q || res_ready_i;
  assign cmd_fire    = cmd_valid_i && cmd_ready_o;
  assign payload     = cmd_byte_i[6:0];
  assign sum         = SumW'(accum_q) | (SumW'(payload) << (7 * idx_q));
  assign sum_over    = (sum >> AccW) != '0;

  always_comb begin
    phase_d     = phase_q;
    held_addr_d = held_addr_q;
    accum_d     = accum_q;
    idx_d       = idx_q;
    sat_d       = sat_q;
    emit        = 1'b0;
    kind_d      = KIND_WRITE;
    addr_d      = '0;
    data_d      = '0;
    ticks_d     = '0;

    case (phase_q)
      PH_OPCODE: begin
        case (cmd_byte_i)
          OP_WRITE: begin
            phase_d = PH_ADDR;
          end
          OP_WAIT1: begin
            emit    = 1'b1;
            kind_d  = KIND_WAIT;
            ticks_d = TicksOne;
          end
          OP_WAITN: begin
            accum_d = '0;
            idx_d   = '0;
            sat_d   = 1'b0;
            phase_d = PH_VARINT;
          end
          OP_END: begin
            emit    = 1'b1;
            kind_d  = KIND_END;
            phase_d = PH_ENDED;
          end
          default: begin
            emit    = 1'b1;
            kind_d  = KIND_UNKNOWN;
            addr_d  = cmd_byte_i;
            phase_d = PH_SKIP1;
          end
        endcase
      end
      PH_ADDR: begin
        held_addr_d = cmd_byte_i;
        phase_d     = PH_DATA;
      end
      PH_DATA: begin
        emit    = 1'b1;
        kind_d  = KIND_WRITE;
        addr_d  = held_addr_q;
        data_d  = cmd_byte_i;
        phase_d = PH_OPCODE;
      end
      PH_VARINT: begin
        if (idx_q < IdxMax) begin
          accum_d = sum[AccW-1:0];
          idx_d   = idx_q + IdxW'(1);
          if (sum_over) begin
            sat_d = 1'b1;
          end
        end else if (payload != '0) begin
          sat_d = 1'b1;
        end
        if (!cmd_byte_i[7]) begin
          emit    = 1'b1;
          kind_d  = KIND_WAIT;
          ticks_d = sat_d ? TicksSat : ({1'b0, accum_d} + TicksW'(2));
          accum_d = '0;
          idx_d   = '0;
          sat_d   = 1'b0;
          phase_d = PH_OPCODE;
        end
      end
      PH_SKIP1: begin
        phase_d = PH_SKIP2;
      end
      PH_SKIP2: begin
        phase_d = PH_OPCODE;
      end
      PH_ENDED: begin
        phase_d = PH_ENDED;
      end
      default: begin
        phase_d = PH_OPCODE;
      end
    endcase
  end

  assign res_valid_d = (cmd_fire && emit) || (res_valid_q && !res_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_OPCODE;
      held_addr_q <= '0;
      accum_q     <= '0;
      idx_q       <= '0;
      sat_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (cmd_fire) begin
        phase_q     <= phase_d;
        held_addr_q <= held_addr_d;
        accum_q     <= accum_d;
        idx_q       <= idx_d;
        sat_q       <= sat_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_fire && emit) begin
      kind_q  <= kind_d;
      addr_q  <= addr_d;
      data_q  <= data_d;
      ticks_q <= ticks_d;
    end
  end

  assign res_valid_o   = res_valid_q;
  assign kind_o        = kind_q;
  assign reg_address_o = addr_q;
  assign reg_data_o    = data_q;
  assign wait_ticks_o  = ticks_q;

  `S98CSP_ASSERT(a_wait_nonzero, (res_valid_o && kind_o == KIND_WAIT) |-> (wait_ticks_o != '0), "Wait result with zero ticks.")
  `S98CSP_ASSERT(a_idx_bound, idx_q <= IdxMax, "Varint byte index ran past its limit.")
  `S98CSP_ASSERT_NEXT(a_addr_to_data, cmd_fire && phase_q == PH_ADDR, phase_q == PH_DATA && !res_valid_o, "Address word did not lead to the data phase.")
  `S98CSP_ASSERT_NEXT(a_ended_silent, phase_q == PH_ENDED && !res_valid_o, phase_q == PH_ENDED && !res_valid_o, "Result produced after end of stream.")

endmodule
